FILE: rtl/dcfe_pkg.sv
// ----------------------------------------------------------------------------
// dcfe_pkg
// shared types and constants of the der certificate field extractor
// ----------------------------------------------------------------------------
package dcfe_pkg;

    // default number of long-form length bytes that are accepted
    localparam int DEF_MAX_LENGTH_BYTES = 4;

    // characters in one utc time field
    localparam int TIME_CHARS = 12;

    // bytes between the issuer and not-before, and between the two times
    localparam int GAP_BEFORE_TIME   = 4;
    localparam int GAP_BETWEEN_TIMES = 3;

    // result field codes
    localparam logic [1:0] FIELD_SERIAL     = 2'd0;
    localparam logic [1:0] FIELD_NOT_BEFORE = 2'd1;
    localparam logic [1:0] FIELD_NOT_AFTER  = 2'd2;
    localparam logic [1:0] FIELD_LEN_ERROR  = 2'd3;

    // parse phase, one-hot
    typedef enum logic [14:0] {
        PH_IDLE      = 15'b000_0000_0000_0001,
        PH_OUTER_HDR = 15'b000_0000_0000_0010,
        PH_TBS_HDR   = 15'b000_0000_0000_0100,
        PH_VER_HDR   = 15'b000_0000_0000_1000,
        PH_VER_SKIP  = 15'b000_0000_0001_0000,
        PH_SER_HDR   = 15'b000_0000_0010_0000,
        PH_SER_EMIT  = 15'b000_0000_0100_0000,
        PH_ALG_HDR   = 15'b000_0000_1000_0000,
        PH_ALG_SKIP  = 15'b000_0001_0000_0000,
        PH_ISS_HDR   = 15'b000_0010_0000_0000,
        PH_ISS_SKIP  = 15'b000_0100_0000_0000,
        PH_GAP1      = 15'b000_1000_0000_0000,
        PH_NB_EMIT   = 15'b001_0000_0000_0000,
        PH_GAP2      = 15'b010_0000_0000_0000,
        PH_NA_EMIT   = 15'b100_0000_0000_0000
    } phase_t;

    // step inside a tlv header, one-hot
    typedef enum logic [2:0] {
        HS_TAG  = 3'b001,
        HS_LEN  = 3'b010,
        HS_LONG = 3'b100
    } hdr_step_t;

    // one result word
    typedef struct packed {
        logic [1:0] field;
        logic [7:0] value;
        logic       last;
    } result_t;

endpackage

FILE: rtl/dcfe_stream_if.sv
// ----------------------------------------------------------------------------
// dcfe byte and result channels
// valid/ready channels carrying certificate bytes in and field words out
// ----------------------------------------------------------------------------
interface dcfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface dcfe_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] field;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output field, output value, output last, input ready);
    modport sink (input valid, input field, input value, input last, output ready);
endinterface

FILE: rtl/dcfe_core.sv
// ----------------------------------------------------------------------------
// dcfe_core
// tlv walker: parse state registers and the per-byte next-state logic
// ----------------------------------------------------------------------------
module dcfe_core
    import dcfe_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       start_req,
    output logic       res_valid,
    output result_t    res
);

    localparam int LEN_W = 8 * MAX_LENGTH_BYTES;
    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    phase_t             phase_reg, phase_next;
    hdr_step_t          header_step_reg, header_step_next;
    logic [LEN_W-1:0]   length_accum_reg, length_accum_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [CNT_W-1:0]   length_bytes_left_reg, length_bytes_left_next;

    // state as seen by this byte, after a possible restart
    phase_t             ph;
    hdr_step_t          hs;
    logic [LEN_W-1:0]   acc;
    logic [LEN_W-1:0]   bl;
    logic [CNT_W-1:0]   lbl;

    logic               hdr_done;
    logic               body_done;
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   bl_dec;
    logic [CNT_W-1:0]   lbl_dec;
    logic [6:0]         len_of_len;

    always_comb
    begin
        ph  = start_req ? PH_OUTER_HDR : phase_reg;
        hs  = start_req ? HS_TAG : header_step_reg;
        acc = start_req ? '0 : length_accum_reg;
        bl  = start_req ? '0 : bytes_left_reg;
        lbl = start_req ? '0 : length_bytes_left_reg;

        phase_next             = ph;
        header_step_next       = hs;
        length_accum_next      = acc;
        bytes_left_next        = bl;
        length_bytes_left_next = lbl;

        res_valid  = 1'b0;
        res        = '0;
        hdr_done   = 1'b0;
        body_done  = 1'b0;
        hdr_len    = '0;
        len_of_len = data_byte[6:0];
        bl_dec     = (bl != '0) ? bl - LEN_W'(1) : '0;
        lbl_dec    = (lbl != '0) ? lbl - CNT_W'(1) : '0;

        case (ph)
            PH_OUTER_HDR, PH_TBS_HDR, PH_VER_HDR, PH_SER_HDR, PH_ALG_HDR, PH_ISS_HDR:
            begin
                case (hs)
                    HS_TAG:
                    begin
                        header_step_next = HS_LEN;
                    end
                    HS_LEN:
                    begin
                        if (!data_byte[7])
                        begin
                            hdr_done = 1'b1;
                            hdr_len  = LEN_W'(data_byte);
                        end
                        else if (len_of_len == 7'd0 || len_of_len > 7'(MAX_LENGTH_BYTES))
                        begin
                            // bad length-of-length: report and drop the parse
                            phase_next             = PH_IDLE;
                            header_step_next       = HS_TAG;
                            length_accum_next      = '0;
                            bytes_left_next        = '0;
                            length_bytes_left_next = '0;
                            res_valid              = 1'b1;
                            res.field              = FIELD_LEN_ERROR;
                            res.value              = 8'd0;
                            res.last               = 1'b1;
                        end
                        else
                        begin
                            length_bytes_left_next = CNT_W'(len_of_len);
                            length_accum_next      = '0;
                            header_step_next       = HS_LONG;
                        end
                    end
                    default:
                    begin
                        // long-form length bytes, big endian
                        length_accum_next      = LEN_W'(acc << 8) | LEN_W'(data_byte);
                        length_bytes_left_next = lbl_dec;
                        if (lbl_dec == '0)
                        begin
                            hdr_done = 1'b1;
                            hdr_len  = length_accum_next;
                        end
                    end
                endcase
            end
            PH_VER_SKIP, PH_ALG_SKIP, PH_ISS_SKIP, PH_GAP1, PH_GAP2:
            begin
                bytes_left_next = bl_dec;
                body_done       = (bl_dec == '0);
            end
            PH_SER_EMIT, PH_NB_EMIT, PH_NA_EMIT:
            begin
                res_valid = 1'b1;
                res.field = (ph == PH_SER_EMIT) ? FIELD_SERIAL :
                            (ph == PH_NB_EMIT)  ? FIELD_NOT_BEFORE : FIELD_NOT_AFTER;
                res.value = data_byte;
                res.last  = (bl <= LEN_W'(1));
                bytes_left_next = bl_dec;
                body_done       = (bl_dec == '0);
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (hdr_done)
        begin
            header_step_next       = HS_TAG;
            length_accum_next      = '0;
            length_bytes_left_next = '0;
            case (ph)
                PH_OUTER_HDR: phase_next = PH_TBS_HDR;
                PH_TBS_HDR:   phase_next = PH_VER_HDR;
                PH_VER_HDR:
                begin
                    phase_next = (hdr_len == '0) ? PH_SER_HDR : PH_VER_SKIP;
                    if (hdr_len != '0)
                        bytes_left_next = hdr_len;
                end
                PH_SER_HDR:
                begin
                    phase_next = (hdr_len == '0) ? PH_ALG_HDR : PH_SER_EMIT;
                    if (hdr_len != '0)
                        bytes_left_next = hdr_len;
                end
                PH_ALG_HDR:
                begin
                    phase_next = (hdr_len == '0) ? PH_ISS_HDR : PH_ALG_SKIP;
                    if (hdr_len != '0)
                        bytes_left_next = hdr_len;
                end
                PH_ISS_HDR:
                begin
                    if (hdr_len == '0)
                    begin
                        phase_next      = PH_GAP1;
                        bytes_left_next = LEN_W'(GAP_BEFORE_TIME);
                    end
                    else
                    begin
                        phase_next      = PH_ISS_SKIP;
                        bytes_left_next = hdr_len;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end

        if (body_done)
        begin
            case (ph)
                PH_VER_SKIP: phase_next = PH_SER_HDR;
                PH_SER_EMIT: phase_next = PH_ALG_HDR;
                PH_ALG_SKIP: phase_next = PH_ISS_HDR;
                PH_ISS_SKIP:
                begin
                    phase_next      = PH_GAP1;
                    bytes_left_next = LEN_W'(GAP_BEFORE_TIME);
                end
                PH_GAP1:
                begin
                    phase_next      = PH_NB_EMIT;
                    bytes_left_next = LEN_W'(TIME_CHARS);
                end
                PH_NB_EMIT:
                begin
                    phase_next      = PH_GAP2;
                    bytes_left_next = LEN_W'(GAP_BETWEEN_TIMES);
                end
                PH_GAP2:
                begin
                    phase_next      = PH_NA_EMIT;
                    bytes_left_next = LEN_W'(TIME_CHARS);
                end
                default:
                begin
                    phase_next      = PH_IDLE;
                    bytes_left_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_IDLE;
            header_step_reg       <= HS_TAG;
            length_accum_reg      <= '0;
            bytes_left_reg        <= '0;
            length_bytes_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg             <= phase_next;
            header_step_reg       <= header_step_next;
            length_accum_reg      <= length_accum_next;
            bytes_left_reg        <= bytes_left_next;
            length_bytes_left_reg <= length_bytes_left_next;
        end
    end

`ifndef SYNTHESIS
    // a length error always drops the parse back to idle
    a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.field == FIELD_LEN_ERROR |=> phase_reg == PH_IDLE)
        else $error("length error did not return to idle");

    // a restart byte is always taken as the outer tag
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start_req |=> phase_reg == PH_OUTER_HDR && header_step_reg == HS_LEN)
        else $error("restart did not consume the outer tag");

    // outside the header phases the header walker sits at the tag step
    a_step_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VER_SKIP || phase_reg == PH_SER_EMIT || phase_reg == PH_ALG_SKIP ||
         phase_reg == PH_ISS_SKIP || phase_reg == PH_GAP1 || phase_reg == PH_NB_EMIT ||
         phase_reg == PH_GAP2 || phase_reg == PH_NA_EMIT || phase_reg == PH_IDLE)
        |-> header_step_reg == HS_TAG)
        else $error("header step left busy outside a header");
`endif

endmodule

FILE: rtl/der_certificate_field_extractor.sv
// ----------------------------------------------------------------------------
// der_certificate_field_extractor
// pulls serial, not-before and not-after out of a der x.509 byte stream
// ----------------------------------------------------------------------------
// The block takes one certificate byte per word on the item channel; a word
// with start_req set is the first byte of a certificate and restarts any parse
// under way. It walks the outer and to-be-signed sequence headers, skips the
// version, signature-algorithm and issuer elements, and emits one result word
// per serial content byte (field 0) and per not-before and not-after character
// (fields 1 and 2), with last set on the final byte of each field. A long-form
// length with zero or more than MAX_LENGTH_BYTES length bytes gives a single
// error word (field 3, value 0, last 1) and the parser goes idle. A new byte
// is accepted on every edge while the item channel is ready. Each result is
// registered in the output register, which drives the result channel, or
// in a one-word skid register behind it while the output register is
// stalled; the item channel stalls only while both hold a word, i.e. when
// the result side has been stalled for more than one result.
// ----------------------------------------------------------------------------
module der_certificate_field_extractor
    import dcfe_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = DEF_MAX_LENGTH_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    dcfe_byte_if.sink     item,
    dcfe_result_if.source result
);

    logic    accept;
    logic    res_valid;
    result_t res;

    // output register and skid register
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    out_fire;

    // byte side stalls only when both result slots are full
    assign item.ready = !skid_valid_reg;
    assign accept     = item.valid && item.ready;
    assign out_fire   = out_valid_reg && result.ready;

    dcfe_core #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (item.data_byte),
        .start_req (item.start_req),
        .res_valid (res_valid),
        .res       (res)
    );

    // control: who holds a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // drain the skid word into the output slot
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_reg <= skid_reg;
        end
        else if (accept && res_valid)
        begin
            if (out_valid_reg && !out_fire)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.field = out_reg.field;
    assign result.value = out_reg.value;
    assign result.last  = out_reg.last;

`ifndef SYNTHESIS
    // the skid slot is only ever used behind a full output slot
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without an output word");

    // the skid slot fills only when the output slot was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready && res_valid))
        else $error("skid filled while output slot was free");

    // a draining skid word keeps the output slot occupied
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && result.ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word lost on drain");
`endif

endmodule
